// File: rtl/bzp_pkg.sv
`default_nettype none

package bzp_pkg;

    // configuration register indexes
    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t REG_ZOOM_FACTOR = 2'd0;
    localparam cfg_index_t REG_KERNEL_A    = 2'd1;

    localparam int ZOOM_W     = 5;
    localparam int KERNEL_A_W = 9;
    localparam int CFG_DATA_W = 9;
    localparam int PIX_W      = 8;

    localparam logic [ZOOM_W-1:0]            ZOOM_RESET     = 5'd4;
    localparam logic signed [KERNEL_A_W-1:0] KERNEL_A_RESET = -9'sd128;
    localparam logic [PIX_W-1:0]             PIX_MAX        = 8'd255;

    // weight table sequencer
    typedef enum logic [3:0] {
        ST_START,
        ST_TAP,
        ST_POW1,
        ST_POW2,
        ST_NUM1,
        ST_NUM2,
        ST_NUM3,
        ST_DIV,
        ST_NEXT,
        ST_READY
    } bzp_state_t;

endpackage

`default_nettype wire

// File: rtl/bicubic_zoom_pixel_core.sv
// channel  | direction | handshake              | beat contents
// ---------+-----------+------------------------+-------------------------------------------
// win      | in        | win_valid / win_stall  | window_row_0..3, phase_x, phase_y
// res      | out       | res_valid / res_stall  | out_pixel, clipped
// cfg      | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one window beat per cycle while win_stall is low
// weights come from a per-phase table built by a shared serial divider, one quotient bit a
//   cycle; win_stall is high while the k rows are built (k = zoom factor)
// the table is rebuilt after reset and after every cfg beat; cfg_ready is always high
// rst_n is asynchronous, active low, and resets valids, sequencer state and config registers
// a held res_stall freezes the pipe stage by stage; bubbles are squeezed out first
`default_nettype none

module bicubic_zoom_pixel_core #(
    parameter int MAX_ZOOM         = 16,
    parameter int WEIGHT_FRAC_BITS = 14
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire bzp_pkg::cfg_index_t           cfg_index,
    input  wire logic [bzp_pkg::CFG_DATA_W-1:0] cfg_data,

    input  wire logic                          win_valid,
    output logic                               win_stall,
    input  wire logic [31:0]                   window_row_0,
    input  wire logic [31:0]                   window_row_1,
    input  wire logic [31:0]                   window_row_2,
    input  wire logic [31:0]                   window_row_3,
    input  wire logic [3:0]                    phase_x,
    input  wire logic [3:0]                    phase_y,

    output logic                               res_valid,
    input  wire logic                          res_stall,
    output logic [bzp_pkg::PIX_W-1:0]          out_pixel,
    output logic                               clipped
);

    import bzp_pkg::*;

    // ------------------------------------------------------------------
    // widths
    // ------------------------------------------------------------------
    localparam int F     = WEIGHT_FRAC_BITS;
    localparam int KW    = $clog2(MAX_ZOOM + 1);          // zoom factor k
    localparam int NW    = $clog2(2 * MAX_ZOOM + 1);      // tap distance n, 0..2k
    localparam int PW    = (MAX_ZOOM > 1) ? $clog2(MAX_ZOOM) : 1;  // phase / table row
    localparam int CMPW  = KW + 4;
    localparam int N2W   = 2 * NW;
    localparam int N3W   = 3 * NW;
    localparam int K2W   = 2 * KW;
    localparam int K3W   = 3 * KW;
    localparam int N2KW  = 2 * NW + KW;
    localparam int NK2W  = NW + 2 * KW;
    localparam int NUMW  = 3 * NW + 16;                   // signed kernel numerator
    localparam int DENW  = K3W + 8;                       // 256 * k^3
    localparam int DVDW  = NUMW + F + 1;
    localparam int REMW  = DENW + 1;
    localparam int QB    = F + 1;                         // quotient bits, |w| <= 2^F
    localparam int CNTW  = $clog2(QB + 1);
    localparam int WW    = F + 2;                         // signed weight
    localparam int ROWW  = 4 * WW;
    localparam int PRW   = WW + 9;                        // weight * pixel
    localparam int HW    = PRW + 2;                       // horizontal row sum
    localparam int VW    = HW + WW;                       // row sum * vertical weight
    localparam int ACCW  = VW + 2;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic                         cfg_we;
    logic [ZOOM_W-1:0]            zoom_reg;
    logic signed [KERNEL_A_W-1:0] kern_a_reg;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_reg   <= ZOOM_RESET;
            kern_a_reg <= KERNEL_A_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ZOOM_FACTOR: zoom_reg   <= cfg_data[ZOOM_W-1:0];
                REG_KERNEL_A:    kern_a_reg <= $signed(cfg_data[KERNEL_A_W-1:0]);
                default:         ;
            endcase
        end
    end

    // effective zoom: zero reads as one, large values saturate
    logic [KW-1:0] k_eff;

    always_comb
    begin
        if (zoom_reg == '0)
            k_eff = KW'(1);
        else if (32'(zoom_reg) > MAX_ZOOM)
            k_eff = KW'(MAX_ZOOM);
        else
            k_eff = KW'(zoom_reg);
    end

    // ------------------------------------------------------------------
    // weight table builder
    // one row per phase p: {w(2k-p), w(k-p), w(p), w(k+p)}, tap 0 lowest
    // ------------------------------------------------------------------
    bzp_state_t state_reg, state_next;

    logic [KW-1:0]          k_reg;
    logic [PW-1:0]          ph_reg;
    logic [1:0]             tap_reg;
    logic [NW-1:0]          n_reg;
    logic                   near_reg;
    logic                   zero_reg;
    logic [N2W-1:0]         n2_reg;
    logic [K2W-1:0]         k2_reg;
    logic [N3W-1:0]         n3_reg;
    logic [K3W-1:0]         k3_reg;
    logic [N2KW-1:0]        n2k_reg;
    logic [NK2W-1:0]        nk2_reg;
    logic signed [NUMW-1:0] t1_reg;
    logic signed [NUMW-1:0] t2_reg;
    logic signed [NUMW-1:0] poly_reg;
    logic signed [NUMW-1:0] num_reg;
    logic                   neg_reg;
    logic [DENW-1:0]        den_reg;
    logic [REMW-1:0]        rem_reg;
    logic [QB-1:0]          dvd_reg;
    logic [QB-1:0]          q_reg;
    logic [CNTW-1:0]        cnt_reg;
    logic [ROWW-1:0]        row_reg;

    logic [ROWW-1:0]        weight_mem [MAX_ZOOM];

    logic                   busy;
    logic                   mem_we;
    logic                   last_tap;
    logic [NW-1:0]          kn;
    logic [NW-1:0]          pn;
    logic [NW-1:0]          n_sel;
    logic signed [NUMW-1:0] a_ext;
    logic [NUMW-1:0]        num_mag;
    logic [DENW-1:0]        den_w;
    logic [DVDW-1:0]        dvd_w;
    logic [REMW-1:0]        trial;
    logic                   trial_ge;
    logic signed [WW-1:0]   w_fin;
    logic [ROWW-1:0]        row_full;

    assign last_tap = (tap_reg == 2'd3) && (KW'(ph_reg) == k_reg - KW'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_START: state_next = ST_TAP;
            ST_TAP:   state_next = ST_POW1;
            ST_POW1:  state_next = ST_POW2;
            ST_POW2:  state_next = ST_NUM1;
            ST_NUM1:  state_next = ST_NUM2;
            ST_NUM2:  state_next = ST_NUM3;
            ST_NUM3:  state_next = ST_DIV;
            ST_DIV:   state_next = (cnt_reg == CNTW'(1)) ? ST_NEXT : ST_DIV;
            ST_NEXT:  state_next = last_tap ? ST_READY : ST_TAP;
            ST_READY: state_next = ST_READY;
            default:  state_next = ST_START;
        endcase
        if (cfg_we)
            state_next = ST_START;
    end

    // sequencer outputs
    always_comb
    begin
        busy   = 1'b1;
        mem_we = 1'b0;
        case (state_reg)
            ST_READY: busy   = 1'b0;
            ST_NEXT:  mem_we = (tap_reg == 2'd3);
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_START;
        else
            state_reg <= state_next;
    end

    // tap distance n = k+p, p, k-p, 2k-p
    always_comb
    begin
        kn = NW'(k_reg);
        pn = NW'(ph_reg);
        case (tap_reg)
            2'd0:    n_sel = kn + pn;
            2'd1:    n_sel = pn;
            2'd2:    n_sel = kn - pn;
            default: n_sel = (kn << 1) - pn;
        endcase
    end

    // rounding divide setup and one restoring step
    always_comb
    begin
        a_ext    = NUMW'(kern_a_reg);
        num_mag  = num_reg[NUMW-1] ? NUMW'(-num_reg) : NUMW'(num_reg);
        den_w    = {k3_reg, 8'd0};
        dvd_w    = (DVDW'(num_mag) << F) + DVDW'(den_w >> 1);
        trial    = {rem_reg[DENW-1:0], dvd_reg[QB-1]};
        trial_ge = (trial >= {1'b0, den_reg});
        w_fin    = neg_reg ? -WW'(q_reg) : WW'(q_reg);
        row_full = row_reg;
        row_full[tap_reg*WW +: WW] = w_fin;
    end

    // builder datapath, no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_START:
            begin
                k_reg   <= k_eff;
                ph_reg  <= '0;
                tap_reg <= '0;
            end
            ST_TAP:
            begin
                n_reg    <= n_sel;
                near_reg <= (n_sel <= kn);
                zero_reg <= (n_sel >= (kn << 1));
            end
            ST_POW1:
            begin
                n2_reg <= N2W'(n_reg) * N2W'(n_reg);
                k2_reg <= K2W'(k_reg) * K2W'(k_reg);
            end
            ST_POW2:
            begin
                n3_reg  <= N3W'(n2_reg) * N3W'(n_reg);
                k3_reg  <= K3W'(k2_reg) * K3W'(k_reg);
                n2k_reg <= N2KW'(n2_reg) * N2KW'(k_reg);
                nk2_reg <= NK2W'(n_reg) * NK2W'(k2_reg);
            end
            ST_NUM1:
            begin
                t1_reg   <= (a_ext + NUMW'(512)) * $signed(NUMW'(n3_reg));
                t2_reg   <= (a_ext + NUMW'(768)) * $signed(NUMW'(n2k_reg));
                poly_reg <= $signed(NUMW'(n3_reg))
                          - $signed(NUMW'(n2k_reg) << 2) - $signed(NUMW'(n2k_reg))
                          + $signed(NUMW'(nk2_reg) << 3)
                          - $signed(NUMW'(k3_reg) << 2);
            end
            ST_NUM2:
            begin
                if (zero_reg)
                    num_reg <= '0;
                else if (near_reg)
                    num_reg <= t1_reg - t2_reg + $signed(NUMW'(k3_reg) << 8);
                else
                    num_reg <= a_ext * poly_reg;
            end
            ST_NUM3:
            begin
                neg_reg <= num_reg[NUMW-1];
                den_reg <= den_w;
                rem_reg <= REMW'(dvd_w >> QB);
                dvd_reg <= dvd_w[QB-1:0];
                q_reg   <= '0;
                cnt_reg <= CNTW'(QB);
            end
            ST_DIV:
            begin
                rem_reg <= trial_ge ? trial - {1'b0, den_reg} : trial;
                q_reg   <= {q_reg[QB-2:0], trial_ge};
                dvd_reg <= dvd_reg << 1;
                cnt_reg <= cnt_reg - CNTW'(1);
            end
            ST_NEXT:
            begin
                row_reg <= row_full;
                tap_reg <= tap_reg + 2'd1;
                if (tap_reg == 2'd3)
                    ph_reg <= ph_reg + PW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            weight_mem[ph_reg] <= row_full;
    end

    // ------------------------------------------------------------------
    // pixel pipeline
    // s1 table read, s2 horizontal products, s3 row sums,
    // s4 vertical products, s5 total, then the result register
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, res_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
    logic win_accept;

    assign rdy6 = !res_valid_reg || !res_stall;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign win_stall  = busy || !rdy1;
    assign win_accept = win_valid && !win_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg        <= win_accept;
            if (rdy2) v2_reg        <= v1_reg;
            if (rdy3) v3_reg        <= v2_reg;
            if (rdy4) v4_reg        <= v3_reg;
            if (rdy5) v5_reg        <= v4_reg;
            if (rdy6) res_valid_reg <= v5_reg;
        end
    end

    // phase saturated to k-1 selects the table row
    logic [CMPW-1:0] px_ext, py_ext, km1;
    logic [CMPW-1:0] px_sat, py_sat;
    logic [PW-1:0]   addr_x, addr_y;

    always_comb
    begin
        px_ext = CMPW'(phase_x);
        py_ext = CMPW'(phase_y);
        km1    = CMPW'(k_reg) - CMPW'(1);
        px_sat = (px_ext > km1) ? km1 : px_ext;
        py_sat = (py_ext > km1) ? km1 : py_ext;
        addr_x = px_sat[PW-1:0];
        addr_y = py_sat[PW-1:0];
    end

    // s1
    logic [31:0]     rows_s1_reg [4];
    logic [ROWW-1:0] wx_s1_reg;
    logic [ROWW-1:0] wy_s1_reg;

    always_ff @(posedge clk)
    begin
        if (win_accept)
        begin
            rows_s1_reg[0] <= window_row_0;
            rows_s1_reg[1] <= window_row_1;
            rows_s1_reg[2] <= window_row_2;
            rows_s1_reg[3] <= window_row_3;
            wx_s1_reg      <= weight_mem[addr_x];
            wy_s1_reg      <= weight_mem[addr_y];
        end
    end

    // s2
    logic signed [PRW-1:0] prod_next  [4][4];
    logic signed [PRW-1:0] prod_s2_reg [4][4];
    logic [ROWW-1:0]       wy_s2_reg;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                prod_next[r][c] = PRW'($signed(wx_s1_reg[c*WW +: WW]))
                                * PRW'($signed({1'b0, rows_s1_reg[r][8*c +: 8]}));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            prod_s2_reg <= prod_next;
            wy_s2_reg   <= wy_s1_reg;
        end
    end

    // s3
    logic signed [HW-1:0] h_next  [4];
    logic signed [HW-1:0] h_s3_reg [4];
    logic [ROWW-1:0]      wy_s3_reg;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            h_next[r] = HW'(prod_s2_reg[r][0]) + HW'(prod_s2_reg[r][1])
                      + HW'(prod_s2_reg[r][2]) + HW'(prod_s2_reg[r][3]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            h_s3_reg  <= h_next;
            wy_s3_reg <= wy_s2_reg;
        end
    end

    // s4
    logic signed [VW-1:0] vp_next  [4];
    logic signed [VW-1:0] vp_s4_reg [4];

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            vp_next[r] = VW'(h_s3_reg[r]) * VW'($signed(wy_s3_reg[r*WW +: WW]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
            vp_s4_reg <= vp_next;
    end

    // s5
    logic signed [ACCW-1:0] acc_s5_reg;

    always_ff @(posedge clk)
    begin
        if (rdy5 && v4_reg)
        begin
            acc_s5_reg <= ACCW'(vp_s4_reg[0]) + ACCW'(vp_s4_reg[1])
                        + ACCW'(vp_s4_reg[2]) + ACCW'(vp_s4_reg[3]);
        end
    end

    // truncate toward zero, then clamp
    logic              acc_neg;
    logic [ACCW-1:0]   acc_mag;
    logic [ACCW-1:0]   t_mag;
    logic [PIX_W-1:0]  pix_next;
    logic              clip_next;
    logic [PIX_W-1:0]  out_pixel_reg;
    logic              clipped_reg;

    always_comb
    begin
        acc_neg = acc_s5_reg[ACCW-1];
        acc_mag = acc_neg ? ACCW'(-acc_s5_reg) : ACCW'(acc_s5_reg);
        t_mag   = acc_mag >> (2 * F);
        if (acc_neg)
        begin
            pix_next  = '0;
            clip_next = (t_mag != '0);
        end
        else if (t_mag > ACCW'(PIX_MAX))
        begin
            pix_next  = PIX_MAX;
            clip_next = 1'b1;
        end
        else
        begin
            pix_next  = t_mag[PIX_W-1:0];
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy6 && v5_reg)
        begin
            out_pixel_reg <= pix_next;
            clipped_reg   <= clip_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign clipped   = clipped_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_cfg_restarts_build: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (state_reg == ST_START))
        else $error("config beat did not restart the weight build");

    a_quot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NEXT) |-> (q_reg <= QB'(1 << F)))
        else $error("weight quotient exceeds unity");

    a_row_below_k: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (KW'(ph_reg) < k_reg))
        else $error("weight row written past zoom factor");

    a_clip_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && clipped) |-> (out_pixel == '0 || out_pixel == PIX_MAX))
        else $error("clipped result not at a rail");

    a_no_take_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_READY) |=> !$past(win_accept))
        else $error("window beat taken during weight build");

endmodule

`default_nettype wire

// File: test/tb_bicubic_zoom_pixel_core.sv
`default_nettype none

module tb_bicubic_zoom_pixel_core;

    import bzp_pkg::*;

    localparam int MAX_ZOOM  = 16;
    localparam int FRAC_BITS = 14;

    // indexes the block does not decode; a write there must change nothing
    localparam cfg_index_t REG_SPARE_2 = 2'd2;
    localparam cfg_index_t REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [3:0][31:0] rows;
        logic [3:0]       ph_x;
        logic [3:0]       ph_y;
    } window_beat_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             clip;
    } pixel_res_t;

    // directed row: window, phases, and a typed-in result where one is obvious
    typedef struct packed {
        logic [31:0]      r0;
        logic [31:0]      r1;
        logic [31:0]      r2;
        logic [31:0]      r3;
        logic [3:0]       px;
        logic [3:0]       py;
        logic             typed;
        logic [PIX_W-1:0] pix;
        logic             clip;
    } directed_row_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] zoom_data;
        logic [CFG_DATA_W-1:0] coeff_data;
    } reg_setting_t;

    typedef longint tap_set_t [4];

    // ------------------------------------------------------------------
    // clock, reset and the block's ports, all known from time zero
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_index_t            cfg_index = REG_ZOOM_FACTOR;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic        win_valid    = 1'b0;
    logic        win_stall;
    logic [31:0] window_row_0 = '0;
    logic [31:0] window_row_1 = '0;
    logic [31:0] window_row_2 = '0;
    logic [31:0] window_row_3 = '0;
    logic [3:0]  phase_x      = '0;
    logic [3:0]  phase_y      = '0;

    logic             res_valid;
    logic             res_stall = 1'b0;
    logic [PIX_W-1:0] out_pixel;
    logic             clipped;

    always #10 clk = ~clk;

    bicubic_zoom_pixel_core #(
        .MAX_ZOOM         (MAX_ZOOM),
        .WEIGHT_FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .win_valid    (win_valid),
        .win_stall    (win_stall),
        .window_row_0 (window_row_0),
        .window_row_1 (window_row_1),
        .window_row_2 (window_row_2),
        .window_row_3 (window_row_3),
        .phase_x      (phase_x),
        .phase_y      (phase_y),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .out_pixel    (out_pixel),
        .clipped      (clipped)
    );

    // ------------------------------------------------------------------
    // shadow copy of the two registers, updated on each accepted cfg beat
    // ------------------------------------------------------------------
    logic [ZOOM_W-1:0]            zoom_q  = ZOOM_RESET;
    logic signed [KERNEL_A_W-1:0] coeff_q = KERNEL_A_RESET;

    // pixels still owed by the block, oldest first
    pixel_res_t pixel_q [$];
    int         mismatches = 0;

    // idling percentages for the current phase
    int gap_pct   = 0;
    int stall_pct = 0;

    // zoom factor as the datapath uses it: zero acts as one, large values saturate
    function automatic longint zoom_eff();
        longint k;
        k = longint'(zoom_q);
        if (k < 1)
            k = 1;
        if (k > MAX_ZOOM)
            k = MAX_ZOOM;
        return k;
    endfunction

    // one Keys kernel weight at distance n/k, scaled by 2^FRAC_BITS,
    // rounded to nearest with ties away from zero
    function automatic longint keys_weight(longint n, longint k, longint a);
        longint num;
        longint den;
        longint mag;
        longint q;
        if (n <= k)
            num = (a + 512) * n * n * n - (a + 768) * n * n * k + 256 * k * k * k;
        else if (n < 2 * k)
            num = a * (n * n * n - 5 * n * n * k + 8 * n * k * k - 4 * k * k * k);
        else
            return 0;
        num = num * (longint'(1) << FRAC_BITS);
        den = 256 * k * k * k;
        mag = (num < 0) ? -num : num;
        q   = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    // four taps along one axis; a phase at or past k is pulled back to k-1
    function automatic tap_set_t axis_taps(logic [3:0] ph, longint k, longint a);
        tap_set_t w;
        longint   p;
        p = longint'(ph);
        if (p > k - 1)
            p = k - 1;
        w[0] = keys_weight(k + p, k, a);
        w[1] = keys_weight(p, k, a);
        w[2] = keys_weight(k - p, k, a);
        w[3] = keys_weight(2 * k - p, k, a);
        return w;
    endfunction

    // exact weighted sum of the window, truncated toward zero, then clamped
    function automatic pixel_res_t bicubic_pixel(window_beat_t b);
        tap_set_t   wx;
        tap_set_t   wy;
        longint     k;
        longint     a;
        longint     acc;
        longint     t;
        pixel_res_t res;
        int         r;
        int         c;
        k   = zoom_eff();
        a   = longint'(coeff_q);
        wx  = axis_taps(b.ph_x, k, a);
        wy  = axis_taps(b.ph_y, k, a);
        acc = 0;
        for (r = 0; r < 4; r++)
            for (c = 0; c < 4; c++)
                acc += wx[c] * wy[r] * longint'({56'd0, b.rows[r][8*c +: 8]});
        // truncate toward zero: shift the magnitude, not the signed value
        if (acc < 0)
            t = -((-acc) >>> (2 * FRAC_BITS));
        else
            t = acc >>> (2 * FRAC_BITS);
        if (t < 0)
            res = '{pix: '0, clip: 1'b1};
        else if (t > 255)
            res = '{pix: PIX_MAX, clip: 1'b1};
        else
            res = '{pix: t[PIX_W-1:0], clip: 1'b0};
        return res;
    endfunction

    // random window: mostly in-range phases, now and then any 4-bit phase; pixel data is
    // noise, black/white edges that push the sum out of range, a mix, or a flat patch
    function automatic window_beat_t random_window();
        window_beat_t b;
        int           style;
        int           base;
        int           r;
        int           c;
        style = $urandom_range(3);
        base  = $urandom_range(255);
        for (r = 0; r < 4; r++)
            for (c = 0; c < 4; c++)
                case (style)
                    0: b.rows[r][8*c +: 8] = 8'($urandom);
                    1: b.rows[r][8*c +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
                    2: b.rows[r][8*c +: 8] = ($urandom_range(2) == 0) ? 8'($urandom)
                                           : ($urandom_range(1) ? 8'hFF : 8'h00);
                    default: b.rows[r][8*c +: 8] = 8'((base + $urandom_range(16)) % 256);
                endcase
        if ($urandom_range(3) == 0)
        begin
            b.ph_x = 4'($urandom_range(15));
            b.ph_y = 4'($urandom_range(15));
        end
        else
        begin
            b.ph_x = 4'($urandom_range(int'(zoom_eff()) - 1));
            b.ph_y = 4'($urandom_range(int'(zoom_eff()) - 1));
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // driving happens on the falling edge, sampling on the rising edge
    // ------------------------------------------------------------------

    // one window beat; gaps are inserted ahead of it at the current rate,
    // and the expectation is queued at the edge where the beat is taken
    task automatic send_window(input window_beat_t b, input logic typed,
                               input pixel_res_t typed_res);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            win_valid <= 1'b0;
            @(negedge clk);
        end
        window_row_0 <= b.rows[0];
        window_row_1 <= b.rows[1];
        window_row_2 <= b.rows[2];
        window_row_3 <= b.rows[3];
        phase_x      <= b.ph_x;
        phase_y      <= b.ph_y;
        win_valid    <= 1'b1;
        @(posedge clk);
        while (win_stall)
            @(posedge clk);
        pixel_q.push_back(typed ? typed_res : bicubic_pixel(b));
    endtask

    // stop sending and let every owed pixel come out
    task automatic drain();
        @(negedge clk);
        win_valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
    endtask

    // register write; only called with the pipe empty
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_ZOOM_FACTOR: zoom_q  = data[ZOOM_W-1:0];
            REG_KERNEL_A:    coeff_q = data[KERNEL_A_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // a run of random windows; part way through, the sender holds off until
    // the block has handed back everything it owes
    task automatic random_windows(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            if (i == 40)
                drain();
            send_window(random_window(), 1'b0, '0);
        end
    endtask

    // receiver back-pressure, redrawn every cycle
    always @(negedge clk)
        res_stall <= ($urandom_range(99) < stall_pct);

    // result checker: every beat taken on the res channel is matched against
    // the oldest owed pixel, one field at a time
    always @(posedge clk)
    begin
        pixel_res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pixel_q.size() == 0)
            begin
                $display("%0t: unexpected result beat: out_pixel %0d clipped %0b",
                         $time, out_pixel, clipped);
                mismatches++;
            end
            else
            begin
                want = pixel_q.pop_front();
                if (out_pixel !== want.pix)
                begin
                    $display("%0t: out_pixel expected %0d actual %0d",
                             $time, want.pix, out_pixel);
                    mismatches++;
                end
                if (clipped !== want.clip)
                begin
                    $display("%0t: clipped expected %0b actual %0b",
                             $time, want.clip, clipped);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // directed windows, run at the reset setting (k = 4, a = -0.5)
    // at phase 0 the column and row weights are exactly 0,1,0,0, so the
    // result is simply row 1 column 1; at phase 2 they are
    // -1/16, 9/16, 9/16, -1/16, which gives easy sums for the clamps
    // ------------------------------------------------------------------
    directed_row_t directed_rows [19] = '{
        // all black
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'd0, 4'd0,
          1'b1, 8'd0, 1'b0},
        // all white, centre pixel passes straight through
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0, 4'd0,
          1'b1, 8'd255, 1'b0},
        '{32'h0000_0000, 32'h0000_FF00, 32'h0000_0000, 32'h0000_0000, 4'd0, 4'd0,
          1'b1, 8'd255, 1'b0},
        '{32'hDEAD_BEEF, 32'h1234_5678, 32'hCAFE_F00D, 32'h8765_4321, 4'd0, 4'd0,
          1'b1, 8'h56, 1'b0},
        // only the outer columns lit: sum goes negative, clamped to black
        '{32'h0000_0000, 32'hFF00_00FF, 32'h0000_0000, 32'h0000_0000, 4'd2, 4'd0,
          1'b1, 8'd0, 1'b1},
        // only the inner columns lit: overshoot above white
        '{32'h0000_0000, 32'h00FF_FF00, 32'h0000_0000, 32'h0000_0000, 4'd2, 4'd0,
          1'b1, 8'd255, 1'b1},
        // sum of exactly -0.5 truncates to zero and is not flagged
        '{32'h0000_0000, 32'h0000_0008, 32'h0000_0000, 32'h0000_0000, 4'd2, 4'd0,
          1'b1, 8'd0, 1'b0},
        // same two clamps along the vertical axis
        '{32'h0000_FF00, 32'h0000_0000, 32'h0000_0000, 32'h0000_FF00, 4'd0, 4'd2,
          1'b1, 8'd0, 1'b1},
        '{32'h0000_0000, 32'h0000_FF00, 32'h0000_FF00, 32'h0000_0000, 4'd0, 4'd2,
          1'b1, 8'd255, 1'b1},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd2, 4'd2,
          1'b0, 8'd0, 1'b0},
        // phases at and beyond the zoom factor are pulled back to k-1
        '{32'h0102_0304, 32'h1122_3344, 32'h5566_7788, 32'h99AA_BBCC, 4'd15, 4'd15,
          1'b0, 8'd0, 1'b0},
        '{32'h00FF_00FF, 32'hFF00_FF00, 32'h00FF_00FF, 32'hFF00_FF00, 4'd4, 4'd0,
          1'b0, 8'd0, 1'b0},
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_8000, 32'h0000_0000, 4'd0, 4'd15,
          1'b0, 8'd0, 1'b0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 4'd1, 4'd3,
          1'b0, 8'd0, 1'b0},
        '{32'h00FF_00FF, 32'h00FF_00FF, 32'h00FF_00FF, 32'h00FF_00FF, 4'd3, 4'd1,
          1'b0, 8'd0, 1'b0},
        '{32'hFF00_00FF, 32'h00FF_FF00, 32'h00FF_FF00, 32'hFF00_00FF, 4'd3, 4'd3,
          1'b0, 8'd0, 1'b0},
        '{32'h3C5A_96E1, 32'h7F80_01FE, 32'h4B2D_D2B4, 32'h0F1E_2D3C, 4'd8, 4'd12,
          1'b0, 8'd0, 1'b0},
        '{32'hA5A5_A5A5, 32'hA5A5_A5A5, 32'hA5A5_A5A5, 32'hA5A5_A5A5, 4'd1, 4'd1,
          1'b0, 8'd0, 1'b0},
        '{32'h5A5A_5A5A, 32'h5A5A_5A5A, 32'h5A5A_5A5A, 32'h5A5A_5A5A, 4'd2, 4'd3,
          1'b0, 8'd0, 1'b0}
    };

    // fixed register settings, extremes first; later phases draw their own
    // zoom 0 acts as 1, 17 and 31 saturate to 16, a = +255/256 lies outside the
    // nominal range and is used as given; upper data bits on the zoom write are dropped
    reg_setting_t fixed_settings [7] = '{
        '{9'd1,   9'h100},
        '{9'd16,  9'h000},
        '{9'd0,   9'h0FF},
        '{9'h1FF, 9'h180},
        '{9'd2,   9'h1C0},
        '{9'd17,  9'h1A0},
        '{9'h0E3, 9'h080}
    };

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        window_beat_t  b;
        directed_row_t d;
        reg_setting_t  s;
        int            i;
        int            ph;

        // reset once; the weight table build that follows shows up as win_stall
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < 19; i++)
        begin
            d         = directed_rows[i];
            b.rows[0] = d.r0;
            b.rows[1] = d.r1;
            b.rows[2] = d.r2;
            b.rows[3] = d.r3;
            b.ph_x    = d.px;
            b.ph_y    = d.py;
            send_window(b, d.typed, '{pix: d.pix, clip: d.clip});
        end
        random_windows(102);

        // one phase per register setting; the idling pattern rotates through
        // sender gaps, receiver stalls, both, and none
        for (ph = 0; ph < 11; ph++)
        begin
            drain();
            if (ph < 7)
                s = fixed_settings[ph];
            else
                s = '{zoom_data: 9'($urandom), coeff_data: 9'($urandom)};
            if (ph % 2 == 0)
            begin
                write_reg(REG_ZOOM_FACTOR, s.zoom_data);
                write_reg(REG_KERNEL_A, s.coeff_data);
            end
            else
            begin
                write_reg(REG_KERNEL_A, s.coeff_data);
                write_reg(REG_ZOOM_FACTOR, s.zoom_data);
            end
            if (ph % 3 == 2)
            begin
                write_reg(REG_SPARE_2, 9'($urandom));
                write_reg(REG_SPARE_3, 9'($urandom));
            end
            case ((ph + 1) % 4)
                1: begin gap_pct = 45; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 45; end
                3: begin gap_pct = 12; stall_pct = 12; end
                default: begin gap_pct = 0; stall_pct = 0; end
            endcase
            random_windows(102);
        end

        // wait out the last pixels, then keep watching for stray beats
        drain();
        repeat (16) @(posedge clk);

        if (mismatches == 0 && pixel_q.size() == 0)
            $display("PASS bicubic_zoom_pixel_core");
        else
            $display("FAIL bicubic_zoom_pixel_core");
        $finish;
    end

    // watchdog: far beyond the slowest legal run, table rebuilds included
    initial
    begin
        #20000000;
        $display("FAIL bicubic_zoom_pixel_core");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/bzp_pkg.sv
rtl/bicubic_zoom_pixel_core.sv
test/tb_bicubic_zoom_pixel_core.sv
